/* rtl/lrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types, codes and helpers of the linear resampler with fade.
// ----------------------------------------------------------------------------
package lrf_pkg;

  localparam int SampleBitsDef = 16;
  localparam int PhaseBitsDef  = 16;

  localparam int STEP_W  = 20;
  localparam int SVOL_W  = 8;
  localparam int RATE_W  = 18;
  localparam int MS_W    = 16;
  localparam int VOL_W   = 17;
  localparam int FADE_W  = 24;
  localparam int QUO_W   = 17;
  localparam int DVD_W   = 41;
  localparam int FRPR_W  = MS_W + RATE_W;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 20;
  localparam int CNT_W   = 5;

  // frames = floor(floor(ms * rate / 8) / 125), the last step by reciprocal
  localparam int FRY_W   = FRPR_W - 3;
  localparam int RCP_W   = FRY_W + 32;
  localparam int RCP_SH  = 38;
  localparam int FQ_W    = RCP_W - RCP_SH;
  localparam logic [31:0] FRAME_RCP = 32'd2199023256;

  localparam logic [CNT_W-1:0] STEP_DIV_BITS  = CNT_W'(17);

  localparam logic [2:0] ACT_FRAME   = 3'd0;
  localparam logic [2:0] ACT_EOS     = 3'd1;
  localparam logic [2:0] ACT_SET_VOL = 3'd2;
  localparam logic [2:0] ACT_STOP    = 3'd3;
  localparam logic [2:0] ACT_START   = 3'd4;

  localparam logic [IDX_W-1:0] REG_STEP      = 2'd0;
  localparam logic [IDX_W-1:0] REG_START_VOL = 2'd1;
  localparam logic [IDX_W-1:0] REG_MONO      = 2'd2;
  localparam logic [IDX_W-1:0] REG_RATE      = 2'd3;

  typedef struct packed {
    logic      take;
    logic      start;
    logic      load_first;
    logic      load_second;
    logic      shift_frame;
    logic      eos_dup;
    logic      set_vol;
    logic      fmul_frames;
    logic      fmul_step;
    logic      div_start;
    logic      frames_div;
    logic      fade_set;
    logic      fade_apply;
    logic      mul1;
    logic      mul2;
    logic      emit_sample;
    logic      emit_last;
    logic      emit_finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       active;
    logic [1:0] frames;
    logic       phase_lt_one;
    logic       next_last;
    logic       fade_on;
    logic       rem_one;
    logic       stop_flag;
    logic       frames_zero;
    logic       div_busy;
    logic       out_free;
  } stat_t;

  // floor(v * 65536 / 255) = v * 257 + (v == 255)
  function automatic logic [VOL_W-1:0] vol_of(input logic [SVOL_W-1:0] v);
    logic [VOL_W-1:0] r;
    r = {1'b0, v, 8'h00} + {9'b0, v} + {16'b0, (v == 8'hFF)};
    return r;
  endfunction

endpackage

/* rtl/linear_resampler_with_fade.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_resampler_with_fade
// One stereo playback channel: linear interpolation resampler with volume
// and a linear fade-out on stop.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Start, set-volume and ignored items only
// pass the decode state. A source frame is decoded and then produces its
// output frames one after another; while a fade runs, each output frame
// waits for the 17-step serial divider that computes the fade volume. A stop
// with fade takes the fade length in frames from a product and a reciprocal
// multiplication by 1/1000. Stalls on the output side hold up an item in
// progress.
// ----------------------------------------------------------------------------
module linear_resampler_with_fade #(
  parameter int SAMPLE_BITS         = lrf_pkg::SampleBitsDef,
  parameter int PHASE_FRACTION_BITS = lrf_pkg::PhaseBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrf_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [lrf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    action_i,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  logic [lrf_pkg::SVOL_W-1:0]    new_volume_i,
  input  logic [lrf_pkg::MS_W-1:0]      fade_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] out_left_o,
  output logic signed [SAMPLE_BITS-1:0] out_right_o,
  output logic                          finished_o,
  output logic                          last_o
);
  import lrf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lrf_dp #(
    .SAMPLE_BITS         (SAMPLE_BITS),
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .new_volume_i   (new_volume_i),
    .fade_ms_i      (fade_ms_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .finished_o     (finished_o),
    .last_o         (last_o)
  );

endmodule

/* rtl/lrf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_div
// Restoring divider for the fade volume, one quotient bit per cycle, 17 steps.
// ----------------------------------------------------------------------------
module lrf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lrf_pkg::DVD_W-1:0] dividend_i,
  input  logic [lrf_pkg::FADE_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [lrf_pkg::QUO_W-1:0] quo_o
);
  import lrf_pkg::*;

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [FADE_W-1:0] rem_q;
  logic [FADE_W-1:0] den_q;
  logic [QUO_W-1:0]  bits_q;
  logic [QUO_W-1:0]  quo_q;
  logic [FADE_W:0]   trial;
  logic              ge;

  assign trial = {rem_q, bits_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= STEP_DIV_BITS;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      busy_q <= (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= divisor_i;
      quo_q  <= '0;
      rem_q  <= FADE_W'(dividend_i >> QUO_W);
      bits_q <= dividend_i[QUO_W-1:0];
    end else if (busy_q) begin
      rem_q  <= ge ? FADE_W'(trial - {1'b0, den_q}) : trial[FADE_W-1:0];
      bits_q <= {bits_q[QUO_W-2:0], 1'b0};
      quo_q  <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/lrf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_dp
// Datapath: config, channel state, interpolation, volume, fade, output reg.
// ----------------------------------------------------------------------------
module lrf_dp #(
  parameter int SAMPLE_BITS         = lrf_pkg::SampleBitsDef,
  parameter int PHASE_FRACTION_BITS = lrf_pkg::PhaseBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lrf_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [lrf_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic [2:0]                        action_i,
  input  logic signed [SAMPLE_BITS-1:0]     left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]     right_sample_i,
  input  logic [lrf_pkg::SVOL_W-1:0]        new_volume_i,
  input  logic [lrf_pkg::MS_W-1:0]          fade_ms_i,
  input  lrf_pkg::cmd_t                     cmd_i,
  output lrf_pkg::stat_t                    stat_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]     out_left_o,
  output logic signed [SAMPLE_BITS-1:0]     out_right_o,
  output logic                              finished_o,
  output logic                              last_o
);
  import lrf_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int PB  = PHASE_FRACTION_BITS;
  localparam int PHW = PB + 4;
  localparam int CW  = (PHW > STEP_W) ? PHW : STEP_W;
  localparam int VW  = SB + PB + 2;
  localparam int PW  = VW + VOL_W + 1;
  localparam int SH  = PB + 16;
  localparam logic [PHW-1:0] PhOne   = PHW'(1 << PB);
  localparam logic [PHW-1:0] StepMin = PHW'(1 << (PB - 5));
  localparam logic [PHW-1:0] StepMax = PHW'(1 << (PB + 3));
  localparam logic signed [PW-1:0] RndAdd = {{(PW-SH){1'b0}}, {SH{1'b1}}};

  // config
  logic [STEP_W-1:0] step_q;
  logic [SVOL_W-1:0] svol_q;
  logic              mono_q;
  logic [RATE_W-1:0] rate_q;

  // item
  logic [2:0]            act_q;
  logic signed [SB-1:0]  l_q;
  logic signed [SB-1:0]  r_q;
  logic [SVOL_W-1:0]     nvol_q;
  logic [MS_W-1:0]       ms_q;

  // channel
  logic                  active_q;
  logic [1:0]            fseen_q;
  logic signed [SB-1:0]  cur_q [2];
  logic signed [SB-1:0]  nxt_q [2];
  logic [PHW-1:0]        phase_q;
  logic [VOL_W-1:0]      vol_q;
  logic [VOL_W-1:0]      fstart_q;
  logic [FADE_W-1:0]     frem_q;
  logic [FADE_W-1:0]     flen_q;
  logic                  stop_q;

  // arithmetic
  logic signed [VW-1:0]  val_q  [2];
  logic signed [PW-1:0]  prod_q [2];
  logic [DVD_W-1:0]      dvd_q;
  logic [FQ_W-1:0]       fq_q;

  // output register
  logic                  ov_q;
  logic signed [SB-1:0]  ol_q;
  logic signed [SB-1:0]  or_q;
  logic                  ofin_q;
  logic                  olast_q;

  logic [CW-1:0]         step_x;
  logic [PHW-1:0]        step_eff;
  logic [PHW-1:0]        phase_nx;
  logic signed [SB:0]    diff   [2];
  logic signed [PB:0]    ph_s;
  logic signed [VW-1:0]  val_c  [2];
  logic signed [PW-1:0]  prod_c [2];
  logic signed [PW-1:0]  rnd    [2];
  logic signed [PW-1:0]  shr    [2];
  logic [FRPR_W-1:0]     fr_prod;
  logic [FRY_W-1:0]      fr_y;
  logic [RCP_W-1:0]      rcp_prod;
  logic [FADE_W-1:0]     fdone;
  logic [DVD_W-1:0]      st_prod;
  logic                  div_busy;
  logic [QUO_W-1:0]      quo;
  logic [FADE_W-1:0]     frames;
  logic                  out_free;

  assign step_x   = CW'(step_q);
  assign step_eff = (step_x < CW'(StepMin)) ? StepMin :
                    (step_x > CW'(StepMax)) ? StepMax : PHW'(step_x);
  assign phase_nx = phase_q + step_eff;
  assign ph_s     = $signed({1'b0, phase_q[PB-1:0]});

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      diff[c]   = (SB+1)'(nxt_q[c]) - (SB+1)'(cur_q[c]);
      val_c[c]  = (VW'(cur_q[c]) <<< PB) + (VW'(diff[c]) * VW'(ph_s));
      prod_c[c] = PW'(val_q[c]) * PW'($signed({1'b0, vol_q}));
      rnd[c]    = prod_q[c] + (prod_q[c][PW-1] ? RndAdd : '0);
      shr[c]    = rnd[c] >>> SH;
    end
  end

  assign fr_prod  = FRPR_W'(ms_q) * FRPR_W'(rate_q);
  assign fr_y     = dvd_q[FRPR_W-1:3];
  assign rcp_prod = RCP_W'(fr_y) * RCP_W'(FRAME_RCP);
  assign fdone    = flen_q - frem_q;
  assign st_prod  = DVD_W'(fstart_q) * DVD_W'(fdone);
  assign frames   = fq_q[FQ_W-1] ? '1 : fq_q[FADE_W-1:0];
  assign out_free = !ov_q || !out_stall_i;

  lrf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_q),
    .divisor_i  (flen_q),
    .busy_o     (div_busy),
    .quo_o      (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_W'(65536);
      svol_q <= 8'hFF;
      mono_q <= 1'b0;
      rate_q <= RATE_W'(48000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_STEP:      step_q <= cfg_wdata_i[STEP_W-1:0];
        REG_START_VOL: svol_q <= cfg_wdata_i[SVOL_W-1:0];
        REG_MONO:      mono_q <= cfg_wdata_i[0];
        REG_RATE:      rate_q <= cfg_wdata_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      act_q  <= action_i;
      l_q    <= left_sample_i;
      r_q    <= mono_q ? left_sample_i : right_sample_i;
      nvol_q <= new_volume_i;
      ms_q   <= fade_ms_i;
    end
    if (cmd_i.mul1) begin
      val_q[0] <= val_c[0];
      val_q[1] <= val_c[1];
    end
    if (cmd_i.mul2) begin
      prod_q[0] <= prod_c[0];
      prod_q[1] <= prod_c[1];
    end
    if (cmd_i.fmul_frames) begin
      dvd_q <= DVD_W'(fr_prod);
    end else if (cmd_i.fmul_step) begin
      dvd_q <= st_prod;
    end
    if (cmd_i.frames_div) begin
      fq_q <= FQ_W'(rcp_prod >> RCP_SH);
    end
    if (cmd_i.emit_sample) begin
      ol_q <= shr[0][SB-1:0];
      or_q <= shr[1][SB-1:0];
    end else if (cmd_i.emit_finish) begin
      ol_q <= '0;
      or_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      ofin_q  <= 1'b0;
      olast_q <= 1'b0;
    end else if (cmd_i.emit_sample || cmd_i.emit_finish) begin
      ov_q    <= 1'b1;
      ofin_q  <= cmd_i.emit_finish;
      olast_q <= cmd_i.emit_finish || cmd_i.emit_last;
    end else if (!out_stall_i) begin
      ov_q    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      fseen_q  <= '0;
      cur_q[0] <= '0;
      cur_q[1] <= '0;
      nxt_q[0] <= '0;
      nxt_q[1] <= '0;
      phase_q  <= '0;
      vol_q    <= '0;
      fstart_q <= '0;
      frem_q   <= '0;
      flen_q   <= '0;
      stop_q   <= 1'b0;
    end else if (cmd_i.start || cmd_i.emit_finish) begin
      active_q <= cmd_i.start;
      fseen_q  <= '0;
      cur_q[0] <= '0;
      cur_q[1] <= '0;
      nxt_q[0] <= '0;
      nxt_q[1] <= '0;
      phase_q  <= '0;
      vol_q    <= cmd_i.start ? vol_of(svol_q) : '0;
      fstart_q <= '0;
      frem_q   <= '0;
      flen_q   <= '0;
      stop_q   <= 1'b0;
    end else if (cmd_i.load_first) begin
      cur_q[0] <= l_q;
      cur_q[1] <= r_q;
      fseen_q  <= 2'd1;
    end else if (cmd_i.load_second) begin
      nxt_q[0] <= l_q;
      nxt_q[1] <= r_q;
      fseen_q  <= 2'd2;
      phase_q  <= '0;
    end else if (cmd_i.shift_frame) begin
      cur_q[0] <= nxt_q[0];
      cur_q[1] <= nxt_q[1];
      nxt_q[0] <= l_q;
      nxt_q[1] <= r_q;
      if (phase_q >= PhOne) begin
        phase_q <= phase_q - PhOne;
      end
    end else if (cmd_i.eos_dup) begin
      nxt_q[0] <= cur_q[0];
      nxt_q[1] <= cur_q[1];
      fseen_q  <= 2'd2;
      phase_q  <= '0;
    end else if (cmd_i.set_vol) begin
      vol_q    <= vol_of(nvol_q);
      frem_q   <= '0;
      flen_q   <= '0;
      stop_q   <= 1'b0;
    end else if (cmd_i.fade_set) begin
      fstart_q <= vol_q;
      flen_q   <= frames;
      frem_q   <= frames;
      stop_q   <= 1'b1;
    end else if (cmd_i.fade_apply) begin
      vol_q    <= (frem_q == FADE_W'(1)) ? '0 : fstart_q - quo;
      frem_q   <= frem_q - FADE_W'(1);
    end else if (cmd_i.emit_sample) begin
      phase_q  <= phase_nx;
    end
  end

  always_comb begin
    stat_o              = '0;
    stat_o.action       = act_q;
    stat_o.active       = active_q;
    stat_o.frames       = fseen_q;
    stat_o.phase_lt_one = (phase_q < PhOne);
    stat_o.next_last    = (phase_nx >= PhOne);
    stat_o.fade_on      = (frem_q != '0) && (flen_q != '0);
    stat_o.rem_one      = (frem_q == FADE_W'(1));
    stat_o.stop_flag    = stop_q;
    stat_o.frames_zero  = (fq_q == '0);
    stat_o.div_busy     = div_busy;
    stat_o.out_free     = out_free;
  end

  assign out_valid_o = ov_q;
  assign out_left_o  = ol_q;
  assign out_right_o = or_q;
  assign finished_o  = ofin_q;
  assign last_o      = olast_q;

  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ofin_q) |-> (ol_q == '0 && or_q == '0 && olast_q))
    else $error("finish item carries a sample");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_sample || cmd_i.emit_finish) |-> out_free)
    else $error("output register overwritten while held");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_stop_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> $past(cmd_i.emit_finish))
    else $error("channel stopped without finish item");

endmodule

/* rtl/lrf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_ctrl
// Sequencer: decodes each item and steps the datapath through its outputs.
// ----------------------------------------------------------------------------
module lrf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lrf_pkg::stat_t  stat_i,
  output lrf_pkg::cmd_t   cmd_o
);
  import lrf_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_LOOP   = 11'b000_0000_0100,
    S_FRDIV  = 11'b000_0000_1000,
    S_FRWAIT = 11'b000_0001_0000,
    S_FDIV   = 11'b000_0010_0000,
    S_FWAIT  = 11'b000_0100_0000,
    S_MUL1   = 11'b000_1000_0000,
    S_MUL2   = 11'b001_0000_0000,
    S_EMIT   = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        if (stat_i.action == ACT_START) begin
          cmd_o.start = 1'b1;
        end else if (stat_i.active) begin
          case (stat_i.action)
            ACT_FRAME: begin
              case (stat_i.frames)
                2'd0: cmd_o.load_first = 1'b1;
                2'd1: begin
                  cmd_o.load_second = 1'b1;
                  state_d           = S_LOOP;
                end
                default: begin
                  cmd_o.shift_frame = 1'b1;
                  state_d           = S_LOOP;
                end
              endcase
            end
            ACT_EOS: begin
              if (stat_i.frames == 2'd1) begin
                cmd_o.eos_dup = 1'b1;
                state_d       = S_LOOP;
              end else begin
                state_d = S_FIN;
              end
            end
            ACT_SET_VOL: cmd_o.set_vol = 1'b1;
            ACT_STOP: begin
              cmd_o.fmul_frames = 1'b1;
              state_d           = S_FRDIV;
            end
            default: ;
          endcase
        end
      end
      S_FRDIV: begin
        cmd_o.frames_div = 1'b1;
        state_d          = S_FRWAIT;
      end
      S_FRWAIT: begin
        if (stat_i.frames_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.fade_set = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_LOOP: begin
        if (stat_i.active && stat_i.phase_lt_one) begin
          if (stat_i.fade_on) begin
            cmd_o.fmul_step = 1'b1;
            state_d         = S_FDIV;
          end else begin
            cmd_o.mul1 = 1'b1;
            state_d    = S_MUL2;
          end
        end else if (stat_i.action == ACT_EOS && stat_i.active) begin
          state_d = S_FIN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FDIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_FWAIT;
      end
      S_FWAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.fade_apply = 1'b1;
          state_d = (stat_i.rem_one && stat_i.stop_flag) ? S_FIN : S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_sample = 1'b1;
          cmd_o.emit_last   = (stat_i.action == ACT_FRAME) && stat_i.next_last;
          state_d           = S_LOOP;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.emit_finish = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_take_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> (state_q == S_DECODE))
    else $error("accepted item not decoded");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_finish |=> !in_stall_o)
    else $error("finish did not end the item");

  a_emit_from_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_EMIT) |-> $past(cmd_o.mul2))
    else $error("sample emitted without product");

endmodule
